// ===== hdl/swd_pkg.sv =====
// Package for the stopwatch with debounced buttons.
// Holds the payload types, digit tables, button indexes and debounce constants.
// Used by the channel interfaces, the cells and the top level.
`timescale 1ns / 1ps

package swd_pkg;

    localparam int DEBOUNCE_TICKS = 3;
    localparam int CNT_W          = $clog2(DEBOUNCE_TICKS + 1);
    localparam int NUM_DIGITS     = 8;
    localparam int NUM_BUTTONS    = 3;

    localparam int BTN_HOLD    = 0;
    localparam int BTN_ADVANCE = 1;
    localparam int BTN_BACK    = 2;

    typedef logic [3:0]       t_digit;
    typedef logic [7:0]       t_image_count;
    typedef logic [CNT_W-1:0] t_bounce;

    // index 0 is the centisecond units digit, index 7 the hour tens digit
    localparam t_digit DIGIT_LIMIT [NUM_DIGITS] = '{
        4'd9, 4'd9, 4'd9, 4'd5, 4'd9, 4'd5, 4'd9, 4'd2
    };
    localparam t_digit WRAP_VALUE [NUM_DIGITS] = '{
        4'd9, 4'd9, 4'd9, 4'd5, 4'd9, 4'd5, 4'd3, 4'd2
    };

    typedef struct packed {
        logic hold_level;
        logic advance_level;
        logic back_level;
    } t_tick;

    typedef struct packed {
        logic [1:0] hour_tens;
        logic [3:0] hour_units;
        logic [2:0] minute_tens;
        logic [3:0] minute_units;
        logic [2:0] second_tens;
        logic [3:0] second_units;
        logic [3:0] centi_tens;
        logic [3:0] centi_units;
        logic [7:0] picture_index;
        logic       running;
    } t_result;

endpackage

// ===== hdl/swd_tick_if.sv =====
// Input channel of the stopwatch: one request per 10 ms tick.
// Carries the sampled button levels; depends on swd_pkg.
`timescale 1ns / 1ps

interface swd_tick_if;
    import swd_pkg::*;

    logic  valid;
    logic  ready;
    t_tick data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/swd_result_if.sv =====
// Result channel of the stopwatch: time digits, picture index and run flag.
// Depends on swd_pkg.
`timescale 1ns / 1ps

interface swd_result_if;
    import swd_pkg::*;

    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/swd_cfg_if.sv =====
// Configuration write channel of the stopwatch: carries the image count.
// Depends on swd_pkg.
`timescale 1ns / 1ps

interface swd_cfg_if;
    import swd_pkg::*;

    logic         valid;
    logic         ready;
    t_image_count data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/swd_digit_cell.sv =====
// One BCD digit cell of the time chain: holds a digit, takes a carry and
// a wrap match from its lower neighbor and hands both on. Depends on swd_pkg.
`timescale 1ns / 1ps

module swd_digit_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  logic            i_run,
    input  logic            i_clear,
    input  logic            i_carry,
    input  logic            i_wrap,
    input  swd_pkg::t_digit i_limit,
    input  swd_pkg::t_digit i_wrap_value,
    output logic            o_carry,
    output logic            o_wrap,
    output swd_pkg::t_digit o_next
);
    import swd_pkg::*;

    t_digit r_digit;
    t_digit n_digit;
    logic   at_limit;

    assign at_limit = (r_digit >= i_limit);
    assign o_carry  = i_carry & at_limit;
    assign o_wrap   = i_wrap & (r_digit == i_wrap_value);

    always_comb begin
        n_digit = r_digit;
        if (i_run) begin
            if (i_clear) begin
                n_digit = '0;
            end else if (i_carry) begin
                n_digit = at_limit ? t_digit'(0) : t_digit'(r_digit + 4'd1);
            end
        end
    end

    assign o_next = n_digit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= '0;
        end else if (i_load) begin
            r_digit <= n_digit;
        end
    end
endmodule

// ===== hdl/swd_debounce.sv =====
// Debounce cell for one active-low button: stable level and bounce count.
// Fires an event when a differing level has been seen long enough. Depends on swd_pkg.
`timescale 1ns / 1ps

module swd_debounce (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  logic i_level,
    output logic o_event
);
    import swd_pkg::*;

    logic    r_stable;
    logic    n_stable;
    t_bounce r_count;
    t_bounce n_count;
    logic    differs;
    logic    fire;

    assign differs = (i_level != r_stable);
    assign fire    = differs && (r_count >= t_bounce'(DEBOUNCE_TICKS));
    assign o_event = fire;

    always_comb begin
        n_stable = fire ? i_level : r_stable;
        n_count  = r_count;
        if (differs) begin
            n_count = fire ? t_bounce'(1) : t_bounce'(r_count + t_bounce'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= 1'b1;
            r_count  <= '0;
        end else if (i_load) begin
            r_stable <= n_stable;
            r_count  <= n_count;
        end
    end
endmodule

// ===== hdl/stopwatch_with_debounced_buttons.sv =====
// Top level of the stopwatch with debounced buttons.
// Instantiates the digit cell chain and the debounce cells; depends on swd_pkg
// and the channel interfaces.
//
// Usage:
//   i_tick carries one request per 10 ms tick with the sampled levels of the
//   hold, advance and back buttons (0 pressed). Each request yields exactly
//   one result on o_result: the eight time digits, picture index and run flag
//   as they stand after that tick.
//   i_cfg writes the image count; it is always ready. Write it only while idle.
//   The result is registered; while the output register is stalled it waits in the skid stage.
//   Throughput: one request per cycle while the skid stage is empty, as the digit chain
//   and debounce update are combinational and loaded on each accepted request.
//   The output register is backed by a one-entry skid stage, so one more
//   request is taken while a result waits; with both full, i_tick.ready drops
//   and rises again in the cycle after o_result.ready returns.
//   Reset: time 00:00:00.00, running, buttons released, picture 0, image
//   count 1, no pending result.
`timescale 1ns / 1ps

module stopwatch_with_debounced_buttons (
    input  logic         i_clk,
    input  logic         i_rst_n,
    swd_tick_if.sink     i_tick,
    swd_cfg_if.sink      i_cfg,
    swd_result_if.source o_result
);
    import swd_pkg::*;

    logic                   accept;
    logic [NUM_BUTTONS-1:0] level;
    logic [NUM_BUTTONS-1:0] event_fire;
    logic [NUM_DIGITS:0]    carry;
    logic [NUM_DIGITS:0]    wrap_chain;
    t_digit                 n_digit [NUM_DIGITS];

    t_image_count r_image_count;
    logic         r_run;
    logic         n_run;
    t_image_count r_pic;
    t_image_count n_pic;
    t_image_count pic_adv;
    t_image_count last;

    t_result result;
    t_result r_out;
    t_result r_skid;
    logic    r_out_valid;
    logic    r_skid_valid;

    assign i_cfg.ready  = 1'b1;
    assign i_tick.ready = !r_skid_valid;
    assign accept       = i_tick.valid && i_tick.ready;

    assign level[BTN_HOLD]    = i_tick.data.hold_level;
    assign level[BTN_ADVANCE] = i_tick.data.advance_level;
    assign level[BTN_BACK]    = i_tick.data.back_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_count <= t_image_count'(1);
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_image_count <= i_cfg.data;
        end
    end

    genvar g;
    generate
        for (g = 0; g < NUM_BUTTONS; g++) begin : g_btn
            swd_debounce u_debounce (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_load  (accept),
                .i_level (level[g]),
                .o_event (event_fire[g])
            );
        end
    endgenerate

    assign carry[0]      = 1'b1;
    assign wrap_chain[0] = 1'b1;

    generate
        for (g = 0; g < NUM_DIGITS; g++) begin : g_digit
            swd_digit_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_load       (accept),
                .i_run        (r_run),
                .i_clear      (wrap_chain[NUM_DIGITS]),
                .i_carry      (carry[g]),
                .i_wrap       (wrap_chain[g]),
                .i_limit      (DIGIT_LIMIT[g]),
                .i_wrap_value (WRAP_VALUE[g]),
                .o_carry      (carry[g+1]),
                .o_wrap       (wrap_chain[g+1]),
                .o_next       (n_digit[g])
            );
        end
    endgenerate

    always_comb begin
        last  = t_image_count'(((r_image_count == '0) ? t_image_count'(1) : r_image_count)
                - t_image_count'(1));
        n_run = event_fire[BTN_HOLD] ? level[BTN_HOLD] : r_run;

        pic_adv = r_pic;
        if (event_fire[BTN_ADVANCE] && !level[BTN_ADVANCE]) begin
            pic_adv = (r_pic >= last) ? t_image_count'(0) : t_image_count'(r_pic + 8'd1);
        end

        n_pic = pic_adv;
        if (event_fire[BTN_BACK] && !level[BTN_BACK]) begin
            n_pic = ((pic_adv == '0) || (pic_adv > last)) ? last
                                                           : t_image_count'(pic_adv - 8'd1);
        end
    end

    always_comb begin
        result.hour_tens     = n_digit[7][1:0];
        result.hour_units    = n_digit[6];
        result.minute_tens   = n_digit[5][2:0];
        result.minute_units  = n_digit[4];
        result.second_tens   = n_digit[3][2:0];
        result.second_units  = n_digit[2];
        result.centi_tens    = n_digit[1];
        result.centi_units   = n_digit[0];
        result.picture_index = n_pic;
        result.running       = n_run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b1;
            r_pic <= '0;
        end else if (accept) begin
            r_run <= n_run;
            r_pic <= n_pic;
        end
    end

    // hold a result in the skid stage while the output register is stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || o_result.ready) begin
            r_out_valid  <= r_skid_valid || accept;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || o_result.ready) begin
            r_out <= r_skid_valid ? r_skid : result;
        end else if (accept) begin
            r_skid <= result;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;
endmodule

// ===== hdl/swd_checker.sv =====
// Port-level checker for the stopwatch with debounced buttons, with its bind.
// Depends on swd_pkg and the top level's ports.
`timescale 1ns / 1ps

module swd_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             tick_valid,
    input logic             tick_ready,
    input logic             out_valid,
    input logic             out_ready,
    input swd_pkg::t_result out_data
);
    import swd_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_valid && tick_ready |=> out_valid)
        else $error("accepted request produced no result");

    a_backpressure_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !tick_ready |-> out_valid && !$past(out_ready))
        else $error("input stalled without a waiting result");

    a_hours_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (out_data.hour_tens < 2'd2) || (out_data.hour_units <= 4'd3))
        else $error("hour beyond 23");
endmodule

bind stopwatch_with_debounced_buttons swd_checker u_swd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .tick_valid (i_tick.valid),
    .tick_ready (i_tick.ready),
    .out_valid  (o_result.valid),
    .out_ready  (o_result.ready),
    .out_data   (o_result.data)
);

// ===== verif/stopwatch_with_debounced_buttons_test.sv =====
// Testbench for the stopwatch with debounced buttons: drives ticks with random button
// gestures and stalls, and checks each readout against a typed row or a stopwatch model.
// Depends on swd_pkg, the three channel interfaces and the top level.
`timescale 1ns / 1ps

module stopwatch_with_debounced_buttons_test;
    import swd_pkg::*;

    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int LONG_HOLD_CYCLES  = 80;
    localparam int PHASE_TICKS       = 105;
    localparam int NUM_PHASES        = 6;
    localparam int DIRECTED_ROWS     = 25;

    localparam t_digit DIGIT_MAX [NUM_DIGITS] = '{
        4'd9, 4'd9, 4'd9, 4'd5, 4'd9, 4'd5, 4'd9, 4'd2
    };
    localparam t_digit DAY_END [NUM_DIGITS] = '{
        4'd9, 4'd9, 4'd9, 4'd5, 4'd9, 4'd5, 4'd3, 4'd2
    };
    localparam logic [7:0] PHASE_COUNT [NUM_PHASES] = '{
        8'd255, 8'd5, 8'd0, 8'd0, 8'd2, 8'd1
    };
    localparam int RANDOM_COUNT_PHASE = 3;

    // levels are {hold, advance, back}, 0 pressed; typed rows show 00:00:00.0c, picture 0
    typedef struct packed {
        logic [2:0] levels;
        logic       typed;
        logic [3:0] centi_units;
        logic       running;
    } t_stim_row;

    localparam t_stim_row STIM_TABLE [DIRECTED_ROWS] = '{
        '{3'b111, 1'b1, 4'd1, 1'b1},
        '{3'b011, 1'b0, 4'd0, 1'b0},
        '{3'b011, 1'b0, 4'd0, 1'b0},
        '{3'b011, 1'b0, 4'd0, 1'b0},
        '{3'b011, 1'b1, 4'd5, 1'b0},
        '{3'b111, 1'b0, 4'd0, 1'b0},
        '{3'b111, 1'b0, 4'd0, 1'b0},
        '{3'b111, 1'b0, 4'd0, 1'b0},
        '{3'b111, 1'b0, 4'd0, 1'b0},
        '{3'b101, 1'b0, 4'd0, 1'b0},
        '{3'b101, 1'b0, 4'd0, 1'b0},
        '{3'b101, 1'b0, 4'd0, 1'b0},
        '{3'b101, 1'b0, 4'd0, 1'b0},
        '{3'b111, 1'b0, 4'd0, 1'b0},
        '{3'b111, 1'b0, 4'd0, 1'b0},
        '{3'b111, 1'b0, 4'd0, 1'b0},
        '{3'b111, 1'b0, 4'd0, 1'b0},
        '{3'b110, 1'b0, 4'd0, 1'b0},
        '{3'b110, 1'b0, 4'd0, 1'b0},
        '{3'b110, 1'b0, 4'd0, 1'b0},
        '{3'b110, 1'b0, 4'd0, 1'b0},
        '{3'b000, 1'b0, 4'd0, 1'b0},
        '{3'b010, 1'b0, 4'd0, 1'b0},
        '{3'b111, 1'b0, 4'd0, 1'b0},
        '{3'b000, 1'b0, 4'd0, 1'b0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    swd_tick_if   tick_ch ();
    swd_cfg_if    cfg_ch ();
    swd_result_if result_ch ();

    stopwatch_with_debounced_buttons dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick_ch),
        .i_cfg    (cfg_ch),
        .o_result (result_ch)
    );

    t_digit     clock_digits [NUM_DIGITS];
    logic       clock_running;
    logic       settled_level [NUM_BUTTONS];
    int         bounce_count [NUM_BUTTONS];
    logic [7:0] picture_ptr;
    logic [7:0] image_count_reg;

    t_result pending_readouts [$];
    int      error_count      = 0;
    int      readouts_checked = 0;
    int      ticks_sent       = 0;
    int      idle_cycles      = 0;
    int      sender_idle_pct  = 0;
    int      recv_idle_pct    = 0;
    bit      long_hold_request = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_result advance_stopwatch(input t_tick t);
        logic       lvl [NUM_BUTTONS];
        bit         fired [NUM_BUTTONS];
        bit         at_day_end;
        bit         carry;
        logic [7:0] last;
        t_result    r;

        lvl[BTN_HOLD]    = t.hold_level;
        lvl[BTN_ADVANCE] = t.advance_level;
        lvl[BTN_BACK]    = t.back_level;

        if (clock_running) begin
            at_day_end = 1'b1;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                if (clock_digits[i] != DAY_END[i]) at_day_end = 1'b0;
            end
            if (at_day_end) begin
                for (int i = 0; i < NUM_DIGITS; i++) clock_digits[i] = '0;
            end else begin
                carry = 1'b1;
                for (int i = 0; i < NUM_DIGITS; i++) begin
                    if (carry) begin
                        if (clock_digits[i] >= DIGIT_MAX[i]) begin
                            clock_digits[i] = '0;
                        end else begin
                            clock_digits[i] = clock_digits[i] + 4'd1;
                            carry = 1'b0;
                        end
                    end
                end
            end
        end

        for (int b = 0; b < NUM_BUTTONS; b++) begin
            fired[b] = 1'b0;
            if (lvl[b] != settled_level[b]) begin
                if (bounce_count[b] >= DEBOUNCE_TICKS) begin
                    fired[b]         = 1'b1;
                    settled_level[b] = lvl[b];
                    bounce_count[b]  = 0;
                end
                bounce_count[b]++;
            end
        end

        last = ((image_count_reg == 8'd0) ? 8'd1 : image_count_reg) - 8'd1;

        if (fired[BTN_HOLD]) clock_running = lvl[BTN_HOLD];
        if (fired[BTN_ADVANCE] && !lvl[BTN_ADVANCE]) begin
            if (picture_ptr >= last) picture_ptr = 8'd0;
            else picture_ptr = picture_ptr + 8'd1;
        end
        if (fired[BTN_BACK] && !lvl[BTN_BACK]) begin
            if (picture_ptr == 8'd0 || picture_ptr > last) picture_ptr = last;
            else picture_ptr = picture_ptr - 8'd1;
        end

        r.hour_tens     = clock_digits[7][1:0];
        r.hour_units    = clock_digits[6];
        r.minute_tens   = clock_digits[5][2:0];
        r.minute_units  = clock_digits[4];
        r.second_tens   = clock_digits[3][2:0];
        r.second_units  = clock_digits[2];
        r.centi_tens    = clock_digits[1];
        r.centi_units   = clock_digits[0];
        r.picture_index = picture_ptr;
        r.running       = clock_running;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    // called and returns at a falling edge, valid left high
    task automatic send_tick(input t_tick t, input bit typed, input t_result fixed);
        t_result predicted;
        while ($urandom_range(99) < sender_idle_pct) begin
            tick_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= t;
        @(posedge i_clk);
        while (!tick_ch.ready) @(posedge i_clk);
        predicted = advance_stopwatch(t);
        pending_readouts.push_back(typed ? fixed : predicted);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    task automatic await_readouts();
        tick_ch.valid <= 1'b0;
        while (pending_readouts.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_request) begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES - 1) @(negedge i_clk);
                long_hold_request = 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            if (pending_readouts.size() == 0) begin
                $display("%0t: readout with no request outstanding, got %h",
                         $time, result_ch.data);
                error_count++;
            end else begin
                want = pending_readouts.pop_front();
                check_field("hour_tens", 8'(want.hour_tens),
                            8'(result_ch.data.hour_tens));
                check_field("hour_units", 8'(want.hour_units),
                            8'(result_ch.data.hour_units));
                check_field("minute_tens", 8'(want.minute_tens),
                            8'(result_ch.data.minute_tens));
                check_field("minute_units", 8'(want.minute_units),
                            8'(result_ch.data.minute_units));
                check_field("second_tens", 8'(want.second_tens),
                            8'(result_ch.data.second_tens));
                check_field("second_units", 8'(want.second_units),
                            8'(result_ch.data.second_units));
                check_field("centi_tens", 8'(want.centi_tens),
                            8'(result_ch.data.centi_tens));
                check_field("centi_units", 8'(want.centi_units),
                            8'(result_ch.data.centi_units));
                check_field("picture_index", want.picture_index,
                            result_ch.data.picture_index);
                check_field("running", 8'(want.running), 8'(result_ch.data.running));
                readouts_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((tick_ch.valid === 1'b1 && tick_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1) ||
            (result_ch.valid === 1'b1 && result_ch.ready === 1'b1)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int         start;
        int         n;
        int         btn;
        logic [2:0] press;
        logic [7:0] new_count;
        t_result    fixed;

        tick_ch.valid = 1'b0;
        tick_ch.data  = '1;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = 8'd1;
        i_rst_n       = 1'b0;

        for (int i = 0; i < NUM_DIGITS; i++) clock_digits[i] = '0;
        for (int b = 0; b < NUM_BUTTONS; b++) begin
            settled_level[b] = 1'b1;
            bounce_count[b]  = 0;
        end
        clock_running   = 1'b1;
        picture_ptr     = 8'd0;
        image_count_reg = 8'd1;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        sender_idle_pct = 24;
        recv_idle_pct   = 63;
        for (int row = 0; row < DIRECTED_ROWS; row++) begin
            fixed               = '0;
            fixed.centi_units   = STIM_TABLE[row].centi_units;
            fixed.running       = STIM_TABLE[row].running;
            send_tick(t_tick'(STIM_TABLE[row].levels), STIM_TABLE[row].typed, fixed);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p / 2)
                0: begin
                    sender_idle_pct = 24;
                    recv_idle_pct   = 63;
                end
                1: begin
                    sender_idle_pct = 63;
                    recv_idle_pct   = 24;
                end
                default: begin
                    sender_idle_pct = 0;
                    recv_idle_pct   = 0;
                end
            endcase

            await_readouts();
            new_count = (p == RANDOM_COUNT_PHASE) ? 8'($urandom_range(255)) : PHASE_COUNT[p];
            cfg_ch.valid <= 1'b1;
            cfg_ch.data  <= new_count;
            @(posedge i_clk);
            while (!cfg_ch.ready) @(posedge i_clk);
            image_count_reg = new_count;
            @(negedge i_clk);
            cfg_ch.valid <= 1'b0;

            // hold the output off while ticks keep coming
            if (p == 4) long_hold_request = 1'b1;

            start = ticks_sent;
            while (ticks_sent - start < PHASE_TICKS) begin
                if ($urandom_range(99) < 75) begin
                    btn   = $urandom_range(NUM_BUTTONS - 1);
                    press = 3'b111 & ~(3'b100 >> btn);
                    n = $urandom_range(3);
                    for (int k = 0; k < n; k++) begin
                        send_tick(t_tick'((k % 2 == 0) ? press : 3'b111), 1'b0, '0);
                    end
                    n = $urandom_range(3, 8);
                    for (int k = 0; k < n; k++) send_tick(t_tick'(press), 1'b0, '0);
                    n = $urandom_range(3, 8);
                    for (int k = 0; k < n; k++) send_tick(t_tick'(3'b111), 1'b0, '0);
                end else begin
                    n = $urandom_range(1, 6);
                    for (int k = 0; k < n; k++) begin
                        send_tick(t_tick'(3'($urandom_range(7))), 1'b0, '0);
                    end
                end
            end
        end

        await_readouts();
        repeat (4) @(negedge i_clk);

        $display("Sent %0d ticks and checked %0d readouts over %0d image count settings,",
                 ticks_sent, readouts_checked, NUM_PHASES + 1);
        $display("with button gestures, bounce, random levels and stalls on both sides.");
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/swd_pkg.sv
hdl/swd_tick_if.sv
hdl/swd_result_if.sv
hdl/swd_cfg_if.sv
hdl/swd_digit_cell.sv
hdl/swd_debounce.sv
hdl/stopwatch_with_debounced_buttons.sv
hdl/swd_checker.sv
verif/stopwatch_with_debounced_buttons_test.sv
